// ----- design/lge_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and types of the life grid generation engine.
package lge_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 256;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int GW_W       = $clog2(MAX_WIDTH + 1);
  localparam int GH_W       = $clog2(MAX_HEIGHT + 1);
  localparam int CFG_DATA_W = (GW_W > GH_W) ? GW_W : GH_W;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [3:0] SURVIVE_COUNT = 4'd2;
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_STEP  = 2'd2
  } mode_t;

  typedef struct packed {
    logic load_up;
    logic load_mid;
    logic shift;
    logic use_first;
  } cell_ctl_t;

endpackage

// ----- design/lge_cell.sv -----
`timescale 1ns / 1ps
// One column cell: holds the rows above and at the current row, applies B3/S23.
module lge_cell (
  input  logic                clk,
  input  lge_pkg::cell_ctl_t  ctl,
  input  logic                mem_bit,
  input  logic                in_use,
  input  logic [1:0]          left_sum,
  input  logic [1:0]          right_sum,
  output logic [1:0]          col_sum,
  output logic                next_bit
);

  logic       up_r, mid_r, first_r;
  logic       up_nxt, mid_nxt, first_nxt;
  logic       down;
  logic [3:0] nbr_cnt;

  // last row looks down at the saved old row 0
  assign down    = ctl.use_first ? first_r : mem_bit;
  assign col_sum = 2'({1'b0, up_r} + {1'b0, mid_r} + {1'b0, down});
  assign nbr_cnt = {2'b00, left_sum} + {2'b00, right_sum} + {3'b000, up_r} + {3'b000, down};

  assign next_bit = in_use ? ((nbr_cnt == lge_pkg::BIRTH_COUNT) |
                              (mid_r & (nbr_cnt == lge_pkg::SURVIVE_COUNT)))
                           : mid_r;

  always_comb begin
    up_nxt    = up_r;
    mid_nxt   = mid_r;
    first_nxt = first_r;
    if (ctl.load_up) begin
      up_nxt = mem_bit;
    end
    if (ctl.load_mid) begin
      mid_nxt   = mem_bit;
      first_nxt = mem_bit;
    end
    if (ctl.shift) begin
      up_nxt  = mid_r;
      mid_nxt = down;
    end
  end

  always_ff @(posedge clk) begin
    up_r    <= up_nxt;
    mid_r   <= mid_nxt;
    first_r <= first_nxt;
  end

endmodule

// ----- design/lge_cell_row.sv -----
`timescale 1ns / 1ps
// Row of column cells with toroidal wrap at the width in use.
module lge_cell_row (
  input  logic                              clk,
  input  lge_pkg::cell_ctl_t                ctl,
  input  logic [lge_pkg::MAX_WIDTH-1:0]     mem_row,
  input  logic [lge_pkg::COL_W-1:0]         w_last,
  output logic [lge_pkg::MAX_WIDTH-1:0]     new_row
);

  logic [1:0] col_sum [lge_pkg::MAX_WIDTH];
  logic [1:0] wrap_sum;

  assign wrap_sum = col_sum[w_last];

  for (genvar c = 0; c < lge_pkg::MAX_WIDTH; c++) begin : g_col
    localparam int LEFT  = (c + lge_pkg::MAX_WIDTH - 1) % lge_pkg::MAX_WIDTH;
    localparam int RIGHT = (c + 1) % lge_pkg::MAX_WIDTH;

    logic       at_last;
    logic       in_use;
    logic [1:0] left_sum;
    logic [1:0] right_sum;

    assign at_last   = (w_last == lge_pkg::COL_W'(c));
    assign in_use    = (lge_pkg::COL_W'(c) <= w_last);
    assign left_sum  = (c == 0) ? wrap_sum : col_sum[LEFT];
    assign right_sum = at_last ? col_sum[0] : col_sum[RIGHT];

    lge_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .mem_bit   (mem_row[c]),
      .in_use    (in_use),
      .left_sum  (left_sum),
      .right_sum (right_sum),
      .col_sum   (col_sum[c]),
      .next_bit  (new_row[c])
    );
  end

endmodule

// ----- design/lge_grid_mem.sv -----
`timescale 1ns / 1ps
// Grid memory: one row per word, bit-masked write, registered read.
module lge_grid_mem (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [lge_pkg::ROW_W-1:0]     wr_addr,
  input  logic [lge_pkg::MAX_WIDTH-1:0] wr_mask,
  input  logic [lge_pkg::MAX_WIDTH-1:0] wr_data,
  input  logic [lge_pkg::ROW_W-1:0]     rd_addr,
  output logic [lge_pkg::MAX_WIDTH-1:0] rd_data_r
);

  logic [lge_pkg::MAX_WIDTH-1:0] mem [lge_pkg::MAX_HEIGHT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < lge_pkg::MAX_WIDTH; i++) begin
        if (wr_mask[i]) begin
          mem[wr_addr][i] <= wr_data[i];
        end
      end
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ----- design/life_grid_generation_engine.sv -----
`timescale 1ns / 1ps
// Write: taken in idle; the engine stays ready for the next item. Read: the row passes
// the memory's registered read, then the result register; the next item is taken once
// the result is registered (later while an earlier result still waits). Step: three row
// loads, then one grid row per cycle through the cell row and the memory's single read
// and write port; input held off. Reset (synchronous, active low): clearing pass, one memory
// row per cycle, no input taken until it ends; configuration writes are taken throughout.
module life_grid_generation_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_mode,
  input  logic [lge_pkg::COL_W-1:0]      in_col,
  input  logic [lge_pkg::ROW_W-1:0]      in_row,
  input  logic                           in_alive_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_alive_out,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [lge_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD_UP,
    ST_LOAD_MID,
    ST_LOAD_DN,
    ST_CALC
  } state_t;

  localparam logic [lge_pkg::ROW_W-1:0] ROW_LAST = lge_pkg::ROW_W'(lge_pkg::MAX_HEIGHT - 1);

  state_t                        state_r, state_nxt;
  logic [lge_pkg::ROW_W-1:0]     row_r, row_nxt;
  logic [lge_pkg::COL_W-1:0]     col_r, col_nxt;
  logic                          in_range_r, in_range_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_alive_r, out_alive_nxt;
  logic [lge_pkg::GW_W-1:0]      grid_width_r, grid_width_nxt;
  logic [lge_pkg::GH_W-1:0]      grid_height_r, grid_height_nxt;

  logic [lge_pkg::COL_W-1:0]     w_last;
  logic [lge_pkg::ROW_W-1:0]     h_last;
  logic                          in_accept;
  logic                          in_range;
  lge_pkg::cell_ctl_t            ctl;
  logic                          wr_en;
  logic [lge_pkg::ROW_W-1:0]     wr_addr;
  logic [lge_pkg::MAX_WIDTH-1:0] wr_mask;
  logic [lge_pkg::MAX_WIDTH-1:0] wr_data;
  logic [lge_pkg::ROW_W-1:0]     rd_addr;
  logic [lge_pkg::MAX_WIDTH-1:0] rd_data;
  logic [lge_pkg::MAX_WIDTH-1:0] new_row;

  lge_grid_mem u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_mask   (wr_mask),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  lge_cell_row u_cells (
    .clk     (clk),
    .ctl     (ctl),
    .mem_row (rd_data),
    .w_last  (w_last),
    .new_row (new_row)
  );

  // zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (grid_width_r == '0) begin
      w_last = '0;
    end else if (grid_width_r > lge_pkg::GW_W'(lge_pkg::MAX_WIDTH)) begin
      w_last = lge_pkg::COL_W'(lge_pkg::MAX_WIDTH - 1);
    end else begin
      w_last = lge_pkg::COL_W'(grid_width_r - lge_pkg::GW_W'(1));
    end
    if (grid_height_r == '0) begin
      h_last = '0;
    end else if (grid_height_r > lge_pkg::GH_W'(lge_pkg::MAX_HEIGHT)) begin
      h_last = ROW_LAST;
    end else begin
      h_last = lge_pkg::ROW_W'(grid_height_r - lge_pkg::GH_W'(1));
    end
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign in_accept     = in_valid & in_ready;
  assign in_range      = (in_col <= w_last) && (in_row <= h_last);
  assign out_valid     = out_valid_r;
  assign out_alive_out = out_alive_r;

  always_comb begin
    state_nxt       = state_r;
    row_nxt         = row_r;
    col_nxt         = col_r;
    in_range_nxt    = in_range_r;
    out_valid_nxt   = out_valid_r & ~out_ready;
    out_alive_nxt   = out_alive_r;
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    ctl             = '0;
    rd_addr         = in_row;
    wr_en           = 1'b0;
    wr_addr         = in_row;
    wr_mask         = {{(lge_pkg::MAX_WIDTH-1){1'b0}}, 1'b1} << in_col;
    wr_data         = {lge_pkg::MAX_WIDTH{in_alive_in}};

    if (cfg_we) begin
      case (cfg_index)
        lge_pkg::CFG_IDX_WIDTH:  grid_width_nxt  = cfg_data[lge_pkg::GW_W-1:0];
        lge_pkg::CFG_IDX_HEIGHT: grid_height_nxt = cfg_data[lge_pkg::GH_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = row_r;
        wr_mask = '1;
        wr_data = '0;
        row_nxt = row_r + lge_pkg::ROW_W'(1);
        if (row_r == ROW_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (in_mode)
            lge_pkg::MODE_WRITE: wr_en = in_range;
            lge_pkg::MODE_READ: begin
              row_nxt      = in_row;
              col_nxt      = in_col;
              in_range_nxt = in_range;
              state_nxt    = ST_READ;
            end
            lge_pkg::MODE_STEP: state_nxt = ST_LOAD_UP;
            default: ;
          endcase
        end
      end
      ST_READ: begin
        rd_addr = row_r;
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_alive_nxt = in_range_r & rd_data[col_r];
          state_nxt     = ST_IDLE;
        end
      end
      ST_LOAD_UP: begin
        rd_addr   = h_last;
        state_nxt = ST_LOAD_MID;
      end
      ST_LOAD_MID: begin
        rd_addr     = '0;
        ctl.load_up = 1'b1;
        state_nxt   = ST_LOAD_DN;
      end
      ST_LOAD_DN: begin
        rd_addr      = lge_pkg::ROW_W'(1);
        ctl.load_mid = 1'b1;
        row_nxt      = '0;
        state_nxt    = ST_CALC;
      end
      ST_CALC: begin
        // fetch two rows ahead; data lands as the next row's lower neighbour
        rd_addr       = row_r + lge_pkg::ROW_W'(2);
        ctl.shift     = 1'b1;
        ctl.use_first = (row_r == h_last);
        wr_en         = 1'b1;
        wr_addr       = row_r;
        wr_mask       = '1;
        wr_data       = new_row;
        row_nxt       = row_r + lge_pkg::ROW_W'(1);
        if (row_r == h_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      row_r         <= '0;
      out_valid_r   <= 1'b0;
      grid_width_r  <= lge_pkg::GW_W'(lge_pkg::MAX_WIDTH);
      grid_height_r <= lge_pkg::GH_W'(lge_pkg::MAX_HEIGHT);
    end else begin
      state_r       <= state_nxt;
      row_r         <= row_nxt;
      out_valid_r   <= out_valid_nxt;
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
    end
    col_r       <= col_nxt;
    in_range_r  <= in_range_nxt;
    out_alive_r <= out_alive_nxt;
  end

endmodule

// ----- design/lge_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the life grid generation engine, bound to the top level.
module lge_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [1:0]                     in_mode,
  input logic [lge_pkg::COL_W-1:0]      in_col,
  input logic [lge_pkg::ROW_W-1:0]      in_row,
  input logic                           in_alive_in,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_alive_out,
  input logic                           cfg_we,
  input logic                           cfg_index,
  input logic [lge_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic in_txn;

  assign in_txn = in_valid & in_ready;

  // clearing pass holds input off after reset
  a_clear_blocks: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input taken during clearing pass");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_alive_out))
    else $error("stalled result changed");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_txn && (in_mode == lge_pkg::MODE_READ) && !out_valid |-> ##2 out_valid)
    else $error("read transaction gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_txn && (in_mode != lge_pkg::MODE_READ) && !out_valid |=> !out_valid)
    else $error("result without a read transaction");

  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_txn && (in_mode == lge_pkg::MODE_STEP) |=> !in_ready)
    else $error("input taken while a generation runs");

endmodule

bind life_grid_generation_engine lge_checker u_lge_checker (.*);
